FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every active clock edge outside reset
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition in this cycle implies the next-cycle condition
`define ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

FILE: hdl/crt_pkg.sv
package crt_pkg;

    // resolution register
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd20;
    localparam int RES_MIN = 2;

    // curve parameter t, unsigned q1.16 in 0..1
    localparam int T_FRAC = 16;
    localparam int T_W = T_FRAC + 1;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;
    localparam int DIV_CNT_W = $clog2(T_W + 1);

    // accumulator guard bits above the coordinate width
    localparam int ACC_GUARD = 6;

    // window fill level at which a segment is complete
    localparam logic [1:0] WIN_FULL = 2'd3;

    // coefficient added by a horner step
    typedef enum logic [1:0] {
        SEL_C,
        SEL_B,
        SEL_A
    } t_coef_sel;

    // sequencer to datapath controls
    typedef struct packed {
        logic      coef_load;
        logic      acc_load;
        logic      acc_step;
        t_coef_sel sel;
    } t_mac_ctrl;

    // sequencer to t generator controls
    typedef struct packed {
        logic start;
        logic advance;
    } t_tgen_ctrl;

endpackage

FILE: hdl/crt_tgen.sv
module crt_tgen #(
    parameter int DEN_W = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  crt_pkg::t_tgen_ctrl      i_ctrl,
    input  logic [DEN_W-1:0]         i_den,
    output logic [crt_pkg::T_W-1:0]  o_t,
    output logic                     o_ready
);

    logic [crt_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]              r_den;
    logic [DEN_W-1:0]              r_rem;
    logic [crt_pkg::T_W-1:0]       r_quot;
    logic [crt_pkg::T_W-1:0]       r_t;
    logic [DEN_W-1:0]              r_frac;

    logic                          div_bit;
    logic [DEN_W:0]                div_shift;
    logic                          div_ge;
    logic [DEN_W:0]                div_diff;
    logic [DEN_W:0]                frac_sum;
    logic                          frac_wrap;
    logic [DEN_W:0]                frac_diff;

    // restoring divider: one quotient bit of 2^16 / den per cycle
    assign div_bit   = (r_cnt == crt_pkg::DIV_CNT_W'(crt_pkg::T_W));
    assign div_shift = {r_rem, div_bit};
    assign div_ge    = (div_shift >= {1'b0, r_den});
    assign div_diff  = div_shift - {1'b0, r_den};

    // t step: add quotient, carry one when the fraction wraps past den
    assign frac_sum  = {1'b0, r_frac} + {1'b0, r_rem};
    assign frac_wrap = (frac_sum >= {1'b0, r_den});
    assign frac_diff = frac_sum - {1'b0, r_den};

    // divider step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.start) begin
            r_cnt <= crt_pkg::DIV_CNT_W'(crt_pkg::T_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // divider and t accumulator datapath
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_t    <= '0;
            r_frac <= i_den >> 1;
        end else if (r_cnt != '0) begin
            r_rem  <= div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
            r_quot <= {r_quot[crt_pkg::T_W-2:0], div_ge};
        end else if (i_ctrl.advance) begin
            r_frac <= frac_wrap ? frac_diff[DEN_W-1:0] : frac_sum[DEN_W-1:0];
            r_t    <= r_t + r_quot + crt_pkg::T_W'(frac_wrap);
        end
    end

    assign o_t     = r_t;
    assign o_ready = (r_cnt == '0);

endmodule

FILE: hdl/crt_mac.sv
module crt_mac #(
    parameter int COORD_BITS = 24
) (
    input  logic                                                i_clk,
    input  crt_pkg::t_mac_ctrl                                  i_ctrl,
    input  logic [2:0][COORD_BITS-1:0]                          i_p0,
    input  logic [2:0][COORD_BITS-1:0]                          i_p1,
    input  logic [2:0][COORD_BITS-1:0]                          i_p2,
    input  logic [2:0][COORD_BITS-1:0]                          i_p3,
    input  logic [crt_pkg::T_W-1:0]                             i_t,
    output logic [2:0][COORD_BITS+crt_pkg::ACC_GUARD-1:0]       o_acc
);

    localparam int ACC_W  = COORD_BITS + crt_pkg::ACC_GUARD;
    localparam int PROD_W = ACC_W + crt_pkg::T_W + 1;

    logic signed [PROD_W-1:0] t_ext;

    assign t_ext = PROD_W'($signed({1'b0, i_t}));

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [ACC_W-1:0]  e0, e1, e2, e3;
        logic signed [ACC_W-1:0]  ca, cb, cc, cd;
        logic signed [ACC_W-1:0]  r_a, r_b, r_c, r_d;
        logic signed [ACC_W-1:0]  r_acc;
        logic signed [ACC_W-1:0]  coef;
        logic signed [PROD_W-1:0] prod;

        // spline coefficients in 1 fraction bit units
        assign e0 = ACC_W'($signed(i_p0[k]));
        assign e1 = ACC_W'($signed(i_p1[k]));
        assign e2 = ACC_W'($signed(i_p2[k]));
        assign e3 = ACC_W'($signed(i_p3[k]));
        assign ca = e1 <<< 1;
        assign cb = e2 - e0;
        assign cc = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        assign cd = (e1 <<< 1) + e1 - e0 - (e2 <<< 1) - e2 + e3;

        // coefficient for this horner step
        always_comb begin
            unique case (i_ctrl.sel)
                crt_pkg::SEL_C: coef = r_c;
                crt_pkg::SEL_B: coef = r_b;
                crt_pkg::SEL_A: coef = r_a;
                default:        coef = r_a;
            endcase
        end

        // acc * t, floor of the product scaled down by 2^16
        assign prod = PROD_W'(r_acc) * t_ext;

        always_ff @(posedge i_clk) begin
            if (i_ctrl.coef_load) begin
                r_a <= ca;
                r_b <= cb;
                r_c <= cc;
                r_d <= cd;
            end
            if (i_ctrl.acc_load) begin
                r_acc <= r_d;
            end else if (i_ctrl.acc_step) begin
                r_acc <= prod[crt_pkg::T_FRAC +: ACC_W] + coef;
            end
        end

        assign o_acc[k] = r_acc;
    end

endmodule

FILE: hdl/catmull_rom_curve_tessellator_core.sv
// catmull-rom curve tessellator
// input channel (i_in_valid / o_in_ready) takes one control point per beat,
// with i_restart emptying the point window first. The first three points of a
// window only fill it and give no output. Every later point completes p0..p3
// and produces n output beats (o_out_valid / i_out_ready) on the segment
// between p1 and p2, n being the clamped resolution register; the final beat
// of the run carries o_last_of_run.
// i_cfg_we / i_cfg_data write the resolution; values 0 and 1 act as 2, values
// above MAX_POINTS_PER_SEGMENT act as that maximum. Write only while idle.
// Sequence: a completing point first computes the t step with a bit-serial
// divider, then evaluates each curve point in the shared multiply-add datapath
// (three horner steps and an output load); o_in_ready is low throughout.
// A stalled receiver holds the output register and the sequencer waits in its
// output step; no beat is dropped. Reset clears the window, idles the
// sequencer and sets the resolution to 20.
`include "assert_macros.svh"

module catmull_rom_curve_tessellator_core #(
    parameter int MAX_POINTS_PER_SEGMENT = 64,
    parameter int COORD_BITS             = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [crt_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [COORD_BITS-1:0]   i_x_in,
    input  logic signed [COORD_BITS-1:0]   i_y_in,
    input  logic signed [COORD_BITS-1:0]   i_z_in,
    input  logic                           i_restart,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [COORD_BITS-1:0]   o_x_out,
    output logic signed [COORD_BITS-1:0]   o_y_out,
    output logic signed [COORD_BITS-1:0]   o_z_out,
    output logic                           o_last_of_run
);

    localparam int ACC_W = COORD_BITS + crt_pkg::ACC_GUARD;
    localparam int N_W   = $clog2(MAX_POINTS_PER_SEGMENT + 1);
    localparam int DEN_W = $clog2(MAX_POINTS_PER_SEGMENT);
    localparam int CMP_W = (N_W > crt_pkg::CFG_W) ? N_W : crt_pkg::CFG_W;
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EVAL,
        ST_EMIT
    } t_state;

    t_state                        r_state, n_state;
    logic [1:0]                    r_count, n_count;
    crt_pkg::t_coef_sel            r_sel, n_sel;
    logic [DEN_W-1:0]              r_idx, n_idx;
    logic                          r_out_valid, n_out_valid;
    logic [crt_pkg::CFG_W-1:0]     r_cfg;

    logic [2:0][COORD_BITS-1:0]    r_win [3];
    logic [2:0][COORD_BITS-1:0]    r_new;
    logic [2:0][COORD_BITS-1:0]    r_out;
    logic                          r_last;

    logic [2:0][COORD_BITS-1:0]    in_pt;
    logic [2:0][COORD_BITS-1:0]    sat_pt;
    logic [2:0][ACC_W-1:0]         acc;
    logic [CMP_W-1:0]              cfg_ext;
    logic [N_W-1:0]                n_eff;
    logic [DEN_W-1:0]              den;
    logic [crt_pkg::T_W-1:0]       t_cur;
    logic                          tgen_ready;
    logic                          in_fire;
    logic [1:0]                    count_eff;
    logic                          fill;
    logic                          last;
    logic                          out_load;
    logic                          win_fill;
    logic                          win_shift;
    logic                          new_load;
    crt_pkg::t_mac_ctrl            mac_ctrl;
    crt_pkg::t_tgen_ctrl           tgen_ctrl;

    assign in_pt = {i_z_in, i_y_in, i_x_in};

    // resolution clamp and divisor
    assign cfg_ext = CMP_W'(r_cfg);
    always_comb begin
        if (cfg_ext < CMP_W'(crt_pkg::RES_MIN)) begin
            n_eff = N_W'(crt_pkg::RES_MIN);
        end else if (cfg_ext > CMP_W'(MAX_POINTS_PER_SEGMENT)) begin
            n_eff = N_W'(MAX_POINTS_PER_SEGMENT);
        end else begin
            n_eff = N_W'(cfg_ext);
        end
    end
    assign den = DEN_W'(n_eff - N_W'(1));

    // input handshake and window fill decision
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign count_eff  = i_restart ? 2'd0 : r_count;
    assign fill       = (count_eff != crt_pkg::WIN_FULL);
    assign last       = (r_idx == den);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sel       = r_sel;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        mac_ctrl    = '0;
        tgen_ctrl   = '0;
        out_load    = 1'b0;
        win_fill    = 1'b0;
        win_shift   = 1'b0;
        new_load    = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (fill) begin
                        win_fill = 1'b1;
                        n_count  = count_eff + 2'd1;
                    end else begin
                        new_load        = 1'b1;
                        tgen_ctrl.start = 1'b1;
                        n_state         = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                mac_ctrl.coef_load = 1'b1;
                if (tgen_ready) begin
                    mac_ctrl.acc_load = 1'b1;
                    n_idx             = '0;
                    n_sel             = crt_pkg::SEL_C;
                    n_state           = ST_EVAL;
                end
            end
            ST_EVAL: begin
                mac_ctrl.acc_step = 1'b1;
                mac_ctrl.sel      = r_sel;
                unique case (r_sel)
                    crt_pkg::SEL_C: n_sel = crt_pkg::SEL_B;
                    crt_pkg::SEL_B: n_sel = crt_pkg::SEL_A;
                    default:        n_state = ST_EMIT;
                endcase
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    if (last) begin
                        win_shift = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_idx             = r_idx + DEN_W'(1);
                        tgen_ctrl.advance = 1'b1;
                        mac_ctrl.acc_load = 1'b1;
                        n_sel             = crt_pkg::SEL_C;
                        n_state           = ST_EVAL;
                    end
                end
            end
        endcase
    end

    // state, control and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sel       <= crt_pkg::SEL_C;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_cfg       <= crt_pkg::CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sel       <= n_sel;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
        if (out_load) begin
            r_out  <= sat_pt;
            r_last <= last;
        end
    end

    // point window
    always_ff @(posedge i_clk) begin
        if (win_fill) begin
            r_win[count_eff] <= in_pt;
        end
        if (win_shift) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_new;
        end
        if (new_load) begin
            r_new <= in_pt;
        end
    end

    // round the halving half up, then saturate
    for (genvar k = 0; k < 3; k++) begin : g_sat
        logic [ACC_W:0]          rnd;
        logic signed [ACC_W-1:0] half;

        assign rnd  = {acc[k][ACC_W-1], acc[k]} + (ACC_W+1)'(1);
        assign half = $signed(rnd[ACC_W:1]);

        always_comb begin
            if (half > SAT_MAX) begin
                sat_pt[k] = SAT_MAX[COORD_BITS-1:0];
            end else if (half < SAT_MIN) begin
                sat_pt[k] = SAT_MIN[COORD_BITS-1:0];
            end else begin
                sat_pt[k] = half[COORD_BITS-1:0];
            end
        end
    end

    crt_tgen #(
        .DEN_W (DEN_W)
    ) u_tgen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (tgen_ctrl),
        .i_den   (den),
        .o_t     (t_cur),
        .o_ready (tgen_ready)
    );

    crt_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_p0   (r_win[0]),
        .i_p1   (r_win[1]),
        .i_p2   (r_win[2]),
        .i_p3   (r_new),
        .i_t    (t_cur),
        .o_acc  (acc)
    );

    assign o_out_valid   = r_out_valid;
    assign o_x_out       = $signed(r_out[0]);
    assign o_y_out       = $signed(r_out[1]);
    assign o_z_out       = $signed(r_out[2]);
    assign o_last_of_run = r_last;

    // checks
    `ASSERT_HOLDS(a_busy_window_full, (r_state != ST_IDLE) |-> (r_count == crt_pkg::WIN_FULL), "window not full while busy")
    `ASSERT_HOLDS(a_first_t_zero, (r_state == ST_EMIT && r_idx == '0) |-> (t_cur == '0), "first point of run has t not zero")
    `ASSERT_HOLDS(a_last_t_one, (r_state == ST_EMIT && last) |-> (t_cur == crt_pkg::T_ONE), "last point of run has t not one")
    `ASSERT_NEXT(a_run_end_idle, out_load && last, r_state == ST_IDLE && r_last, "run end did not return to idle")

endmodule
